// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the ranking list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/trl_pkg.sv -----
// Package with the field widths, codes and types of the ranking list block.
`default_nettype none

package trl_pkg;

    // Field widths of the transactions.
    localparam int W_MODE   = 3;
    localparam int W_KEY    = 32;
    localparam int W_RANK   = 5;
    localparam int W_STATUS = 2;
    localparam int W_POS    = 5;
    localparam int W_COUNT  = 5;

    // Default geometry of the list.
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    // Operation codes carried in the mode field.
    typedef enum logic [W_MODE-1:0] {
        MODE_ADD      = 3'd0,
        MODE_GET      = 3'd1,
        MODE_CONTAINS = 3'd2,
        MODE_DOWN     = 3'd3,
        MODE_TOP      = 3'd4
    } t_mode;

    // Result status codes.
    typedef enum logic [W_STATUS-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_RD_B,
        S_RD_A,
        S_WR_A,
        S_WR_B,
        S_TOP_RD,
        S_TOP_OUT,
        S_RES
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/trl_if.sv -----
// Valid/ready channel interfaces for requests and results of the ranking list.
`default_nettype none

// Request channel: one operation per transaction.
interface trl_in_if;
    logic                        valid;
    logic                        ready;
    logic [trl_pkg::W_MODE-1:0]  mode;
    logic [trl_pkg::W_KEY-1:0]   key;
    logic [trl_pkg::W_RANK-1:0]  rank;

    modport source (output valid, output mode, output key, output rank, input ready);
    modport sink   (input valid, input mode, input key, input rank, output ready);
endinterface

// Result channel: one result item per transaction.
interface trl_out_if;
    logic                          valid;
    logic                          ready;
    logic [trl_pkg::W_STATUS-1:0]  status;
    logic [trl_pkg::W_KEY-1:0]     key_out;
    logic [trl_pkg::W_POS-1:0]     position;
    logic [trl_pkg::W_COUNT-1:0]   entry_count;
    logic                          last;

    modport source (output valid, output status, output key_out, output position,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input key_out, input position,
                    input entry_count, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/trl_key_ram.sv -----
// Key storage: one write port and one read port with registered read data.
`default_nettype none

module trl_key_ram #(
    parameter int DEPTH    = trl_pkg::DEPTH_DEF,
    parameter int KEY_BITS = trl_pkg::KEY_BITS_DEF,
    localparam int IW      = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [IW-1:0]       i_wr_addr,
    input  wire logic [KEY_BITS-1:0] i_wr_data,
    input  wire logic                i_rd_en,
    input  wire logic [IW-1:0]       i_rd_addr,
    output logic      [KEY_BITS-1:0] o_rd_data
);

    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/transpose_ranking_list_unit.sv -----
// Top level of the transpose-ranked key list with its operation sequencer.
// Add and contains scan one key a cycle; an add that misses appends the key at the bottom,
// and a hit at rank r > 1 swaps the key one place up, as get does with the key it reads.
// Move down swaps a key one place down; read top fetches and hands out one key at a time.
// One request is in work at a time; the next one is taken once the last result is queued.
// Synchronous reset empties the list and idles the sequencer; key storage is not cleared.
`default_nettype none
`include "assert_macros.svh"

module transpose_ranking_list_unit #(
    parameter int DEPTH    = trl_pkg::DEPTH_DEF,
    parameter int KEY_BITS = trl_pkg::KEY_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    trl_in_if.sink     i_in,
    trl_out_if.source  o_out
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > trl_pkg::W_RANK) ? CW : trl_pkg::W_RANK;

    // Sequencer and operation registers.
    trl_pkg::t_state          r_state, n_state;
    logic [trl_pkg::W_MODE-1:0] r_mode, n_mode;
    logic [KEY_BITS-1:0]      r_key, n_key;
    logic [CW-1:0]            r_ptr, n_ptr;
    logic [CW-1:0]            r_n, n_n;
    logic [IW-1:0]            r_idx, n_idx;
    logic                     r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]            r_cmp_idx, n_cmp_idx;
    logic [KEY_BITS-1:0]      r_hold, n_hold;
    trl_pkg::t_status         r_status, n_status;
    logic [KEY_BITS-1:0]      r_rkey, n_rkey;
    logic [CW-1:0]            r_rpos, n_rpos;
    logic [CW-1:0]            r_cnt, n_cnt;

    // Output register.
    logic                     r_ov;
    trl_pkg::t_status         r_ostat;
    logic [KEY_BITS-1:0]      r_okey;
    logic [CW-1:0]            r_opos;
    logic [CW-1:0]            r_ocnt;
    logic                     r_olast;

    // Output load request from the sequencer.
    logic                     ld;
    trl_pkg::t_status         ld_stat;
    logic [KEY_BITS-1:0]      ld_key;
    logic [CW-1:0]            ld_pos;
    logic                     ld_last;
    logic                     slot_free;

    // Memory port controls.
    logic                     ram_wr_en;
    logic [IW-1:0]            ram_wr_addr;
    logic [KEY_BITS-1:0]      ram_wr_data;
    logic                     ram_rd_en;
    logic [IW-1:0]            ram_rd_addr;
    logic [KEY_BITS-1:0]      ram_rd_data;

    // Decode helpers.
    logic [CMPW-1:0]          rank_w;
    logic [CMPW-1:0]          cnt_w;
    logic                     hit;

    trl_key_ram #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign slot_free  = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == trl_pkg::S_IDLE);
    assign rank_w     = CMPW'(i_in.rank);
    assign cnt_w      = CMPW'(r_cnt);
    assign hit        = r_cmp_vld && (ram_rd_data == r_key);

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= trl_pkg::S_IDLE;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Operation payload registers.
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_ptr     <= n_ptr;
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_hold    <= n_hold;
        r_status  <= n_status;
        r_rkey    <= n_rkey;
        r_rpos    <= n_rpos;
    end

    // Next state, memory accesses and result loads.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_ptr       = r_ptr;
        n_n         = r_n;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_hold      = r_hold;
        n_status    = r_status;
        n_rkey      = r_rkey;
        n_rpos      = r_rpos;
        n_cnt       = r_cnt;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = r_hold;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        ld          = 1'b0;
        ld_stat     = r_status;
        ld_key      = r_rkey;
        ld_pos      = r_rpos;
        ld_last     = 1'b1;

        unique case (r_state)
            trl_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_mode    = i_in.mode;
                    n_key     = KEY_BITS'(i_in.key);
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                    n_status  = trl_pkg::ST_MISS;
                    n_rkey    = '0;
                    n_rpos    = '0;
                    n_state   = trl_pkg::S_RES;
                    unique case (i_in.mode)
                        trl_pkg::MODE_ADD, trl_pkg::MODE_CONTAINS: begin
                            n_state = trl_pkg::S_SCAN;
                        end
                        trl_pkg::MODE_GET: begin
                            if (rank_w != '0 && rank_w <= cnt_w) begin
                                n_idx   = IW'(rank_w - CMPW'(1));
                                n_state = trl_pkg::S_RD_B;
                            end
                        end
                        trl_pkg::MODE_DOWN: begin
                            if (rank_w != '0 && rank_w < cnt_w) begin
                                n_idx   = IW'(rank_w);
                                n_state = trl_pkg::S_RD_B;
                            end
                        end
                        trl_pkg::MODE_TOP: begin
                            n_n = CW'((rank_w < cnt_w) ? rank_w : cnt_w);
                            if (rank_w != '0 && cnt_w != '0) begin
                                n_state = trl_pkg::S_TOP_RD;
                            end
                        end
                        default: begin
                            n_state = trl_pkg::S_RES;
                        end
                    endcase
                end
            end

            // One read issued and one compare made per cycle.
            trl_pkg::S_SCAN: begin
                if (hit) begin
                    n_cmp_vld = 1'b0;
                    n_status  = trl_pkg::ST_OK;
                    n_idx     = r_cmp_idx;
                    n_state   = (r_cmp_idx == '0) ? trl_pkg::S_RES : trl_pkg::S_RD_B;
                end else if (r_ptr < r_cnt) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr[IW-1:0];
                    n_cmp_vld   = 1'b1;
                    n_cmp_idx   = r_ptr[IW-1:0];
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_cmp_vld = 1'b0;
                    n_state   = trl_pkg::S_RES;
                    if (r_mode == trl_pkg::MODE_ADD) begin
                        if (r_cnt == CW'(DEPTH)) begin
                            n_status = trl_pkg::ST_FULL;
                        end else begin
                            n_status = trl_pkg::ST_OK;
                            n_state  = trl_pkg::S_APPEND;
                        end
                    end else begin
                        n_status = trl_pkg::ST_MISS;
                    end
                end
            end

            // A new key goes to the bottom of the list.
            trl_pkg::S_APPEND: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_cnt[IW-1:0];
                ram_wr_data = r_key;
                n_cnt       = r_cnt + CW'(1);
                n_state     = trl_pkg::S_RES;
            end

            // Swap sequence: read the lower key, then the upper key.
            trl_pkg::S_RD_B: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_idx;
                n_state     = trl_pkg::S_RD_A;
            end

            trl_pkg::S_RD_A: begin
                n_hold = ram_rd_data;
                if (r_idx == '0) begin
                    n_status = trl_pkg::ST_OK;
                    n_rkey   = ram_rd_data;
                    n_rpos   = CW'(1);
                    n_state  = trl_pkg::S_RES;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_idx - IW'(1);
                    n_state     = trl_pkg::S_WR_A;
                end
            end

            // Lower key moves up one place.
            trl_pkg::S_WR_A: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx - IW'(1);
                ram_wr_data = r_hold;
                n_state     = trl_pkg::S_WR_B;
            end

            // Upper key moves down one place.
            trl_pkg::S_WR_B: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx;
                ram_wr_data = ram_rd_data;
                n_status    = trl_pkg::ST_OK;
                if (r_mode == trl_pkg::MODE_GET) begin
                    n_rkey = r_hold;
                    n_rpos = CW'(r_idx);
                end
                n_state = trl_pkg::S_RES;
            end

            // Read top: fetch one key, then hand it out.
            trl_pkg::S_TOP_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_ptr[IW-1:0];
                n_state     = trl_pkg::S_TOP_OUT;
            end

            trl_pkg::S_TOP_OUT: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_stat = trl_pkg::ST_OK;
                    ld_key  = ram_rd_data;
                    ld_pos  = r_ptr + CW'(1);
                    ld_last = ((r_ptr + CW'(1)) == r_n);
                    n_ptr   = r_ptr + CW'(1);
                    n_state = ld_last ? trl_pkg::S_IDLE : trl_pkg::S_TOP_RD;
                end
            end

            // Single result of the operation.
            trl_pkg::S_RES: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    n_state = trl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = trl_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: loads when empty or when its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_ostat <= ld_stat;
            r_okey  <= ld_key;
            r_opos  <= ld_pos;
            r_ocnt  <= n_cnt;
            r_olast <= ld_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_ostat;
    assign o_out.key_out     = trl_pkg::W_KEY'(r_okey);
    assign o_out.position    = trl_pkg::W_POS'(r_opos);
    assign o_out.entry_count = trl_pkg::W_COUNT'(r_ocnt);
    assign o_out.last        = r_olast;

    // The list never holds more keys than it has room for.
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH), "key count above depth")
    // A pending compare always refers to a held entry.
    `ASSERT_IMPLIES(a_cmp_idx, i_clk, i_rst_n, r_cmp_vld, CW'(r_cmp_idx) < r_cnt,
                    "compare past count")
    // A given-out rank never exceeds the count that goes with it.
    `ASSERT_IMPLIES(a_pos_bound, i_clk, i_rst_n, r_ov, r_opos <= r_ocnt, "position above count")
    // Only read-top results can be followed by more results, and those succeed.
    `ASSERT_IMPLIES(a_not_last, i_clk, i_rst_n, o_out.valid && !o_out.last,
                    o_out.status == trl_pkg::ST_OK, "non-final result failed")

endmodule

`default_nettype wire
